@@ rtl/core/assert_macros.svh @@
// assertion helpers for the rtl files, used by the list engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge, ignored while reset is low
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// plain invariant checked on every rising clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
    `ASSERT_CLK(label, (1'b1) |-> (expr), msg)

`endif

@@ rtl/core/ple_pkg.sv @@
// ----------------------------------------------------------------------------
// ple_pkg
// types and codes shared by the positional list engine and its cells
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

    localparam int POS_W  = 7;
    localparam int WORD_W = 32;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_LIST   = 2'd2;

    localparam logic [1:0] PLACE_FRONT = 2'd0;
    localparam logic [1:0] PLACE_BACK  = 2'd1;
    localparam logic [1:0] PLACE_AT    = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_POS = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_ROTATE = 2'd3
    } t_cell_op;

    // broadcast to every cell of the chain
    typedef struct packed {
        t_cell_op             kind;
        logic [POS_W-1:0]     idx;    // 0-based target slot
        logic [POS_W-1:0]     n;      // entries stored before the update
    } t_cell_cmd;

endpackage

`default_nettype wire

@@ rtl/core/positional_list_engine.sv @@
// ----------------------------------------------------------------------------
// positional_list_engine
// ordered list of signed words kept in a chain of cells with a running count
// ----------------------------------------------------------------------------
// usage:
//   slave channel takes one request: tuser carries op and place, tdata carries
//   position and value. master channel returns results: tdata carries status,
//   count and data_out, tuser carries has_data, tlast marks the final result.
//   insert, delete and unused ops answer with one result registered in the
//   cycle the request is taken, so with a free output they run one request
//   per cycle. a list request of n entries is taken first and then returns
//   one entry per cycle while the output is free, read from the chain head
//   as the chain rotates one place; after n rotations the order is restored.
//   the list of an empty chain returns one empty-status result.
//   tready on the slave side is high only while no listing is in progress and
//   the output register is empty or being taken. a stall on the master side
//   holds the result register and pauses the rotation.
//   reset clears the count and the control state; stored words are not reset
//   and are only read after they were written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module positional_list_engine
    import ple_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [39:0] i_s_axis_tdata,  // position[6:0], value[38:7], zero pad
    input  wire logic [3:0]  i_s_axis_tuser,  // op[1:0], place[3:2]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [47:0]      o_m_axis_tdata,  // status[1:0], count[8:2], data_out[40:9], pad
    output logic             o_m_axis_tuser,  // has_data
    output logic             o_m_axis_tlast
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LIST = 2'b10
    } t_state;

    // input fields
    logic [1:0]            w_op;
    logic [1:0]            w_place;
    logic [POS_W-1:0]      w_position;
    logic [WORD_W-1:0]     w_value;
    logic [DATA_WIDTH-1:0] w_val_st;

    assign w_op       = i_s_axis_tuser[1:0];
    assign w_place    = i_s_axis_tuser[3:2];
    assign w_position = i_s_axis_tdata[6:0];
    assign w_value    = i_s_axis_tdata[38:7];

    // control state
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_remain, n_remain;

    // output register
    logic              r_ovalid, n_ovalid;
    logic [1:0]        r_status, n_status;
    logic [POS_W-1:0]  r_ocount, n_ocount;
    logic [WORD_W-1:0] r_odata, n_odata;
    logic              r_ohas, n_ohas;
    logic              r_olast, n_olast;

    logic              w_out_free;
    logic              w_s_acc;
    t_cell_cmd         w_cmd;
    logic [POS_W:0]    w_n8;
    logic [POS_W:0]    w_pos8;

    logic [DATA_WIDTH-1:0] w_cell [DEPTH];
    logic [WORD_W-1:0]     w_head_ext;

    assign w_out_free      = !r_ovalid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_s_acc         = i_s_axis_tvalid && o_s_axis_tready;
    assign w_n8            = (POS_W + 1)'(r_count);

    generate
        if (DATA_WIDTH >= WORD_W) begin : g_wide
            assign w_val_st   = DATA_WIDTH'(w_value);
            assign w_head_ext = w_cell[0][WORD_W-1:0];
        end else begin : g_narrow
            assign w_val_st   = w_value[DATA_WIDTH-1:0];
            assign w_head_ext = {{(WORD_W - DATA_WIDTH){w_cell[0][DATA_WIDTH-1]}},
                                 w_cell[0]};
        end
    endgenerate

    // effective 1-based position of an insert or delete
    always_comb begin
        case (w_place)
            PLACE_FRONT: w_pos8 = (POS_W + 1)'(1);
            PLACE_BACK:  w_pos8 = (w_op == OP_INSERT) ? (w_n8 + (POS_W + 1)'(1)) : w_n8;
            PLACE_AT:    w_pos8 = {1'b0, w_position};
            default:     w_pos8 = '0;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_remain  = r_remain;
        n_ovalid  = r_ovalid && !i_m_axis_tready;
        n_status  = r_status;
        n_ocount  = r_ocount;
        n_odata   = r_odata;
        n_ohas    = r_ohas;
        n_olast   = r_olast;
        w_cmd.kind = CMD_HOLD;
        w_cmd.idx  = POS_W'(w_pos8 - (POS_W + 1)'(1));
        w_cmd.n    = POS_W'(r_count);

        case (r_state)
            S_IDLE: begin
                if (w_s_acc) begin
                    n_ovalid = 1'b1;
                    n_status = ST_OK;
                    n_odata  = '0;
                    n_ohas   = 1'b0;
                    n_olast  = 1'b1;
                    case (w_op)
                        OP_INSERT: begin
                            if (w_pos8 == '0 || w_pos8 > w_n8 + (POS_W + 1)'(1)) begin
                                n_status = ST_BAD_POS;
                            end else if (r_count >= DEPTH_C) begin
                                n_status = ST_FULL;
                            end else begin
                                w_cmd.kind = CMD_INSERT;
                                n_count    = r_count + CW'(1);
                            end
                        end
                        OP_DELETE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else if (w_pos8 == '0 || w_pos8 > w_n8) begin
                                n_status = ST_BAD_POS;
                            end else begin
                                w_cmd.kind = CMD_DELETE;
                                n_count    = r_count - CW'(1);
                            end
                        end
                        OP_LIST: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_ovalid = 1'b0;
                                n_remain = r_count;
                                n_state  = S_LIST;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                    n_ocount = POS_W'(n_count);
                end
            end
            S_LIST: begin
                if (w_out_free) begin
                    n_ovalid   = 1'b1;
                    n_status   = ST_OK;
                    n_ocount   = POS_W'(r_count);
                    n_odata    = w_head_ext;
                    n_ohas     = 1'b1;
                    n_olast    = (r_remain == CW'(1));
                    w_cmd.kind = CMD_ROTATE;
                    n_remain   = r_remain - CW'(1);
                    if (r_remain == CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_remain <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_remain <= n_remain;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_ocount <= n_ocount;
        r_odata  <= n_odata;
        r_ohas   <= n_ohas;
        r_olast  <= n_olast;
    end

    // chain of cells, slot 0 is the front of the list
    generate
        for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [DATA_WIDTH-1:0] w_prev;
            logic [DATA_WIDTH-1:0] w_next;
            if (gi == 0) begin : g_first
                assign w_prev = '0;
            end else begin : g_mid_p
                assign w_prev = w_cell[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign w_next = '0;
            end else begin : g_mid_n
                assign w_next = w_cell[gi+1];
            end
            ple_cell #(
                .IDX        (gi),
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .i_clk  (i_clk),
                .i_cmd  (w_cmd),
                .i_val  (w_val_st),
                .i_prev (w_prev),
                .i_next (w_next),
                .i_head (w_cell[0]),
                .o_data (w_cell[gi])
            );
        end
    endgenerate

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {7'd0, r_odata, r_ocount, r_status};
    assign o_m_axis_tuser  = r_ohas;
    assign o_m_axis_tlast  = r_olast;

    `ASSERT_ALWAYS(a_count_bound, r_count <= DEPTH_C, "count exceeds depth")
    `ASSERT_CLK(a_list_remain,
        (r_state == S_LIST) |-> (r_remain != '0 && r_remain <= r_count),
        "listing counter out of range")
    `ASSERT_CLK(a_accept_answers,
        w_s_acc |=> (r_ovalid || r_state == S_LIST),
        "accepted request left no result pending")
    `ASSERT_CLK(a_count_on_accept,
        !w_s_acc |=> (r_count == $past(r_count)),
        "count changed without a request")

endmodule

`default_nettype wire

@@ rtl/core/ple_cell.sv @@
// ----------------------------------------------------------------------------
// ple_cell
// one slot of the list chain: holds one word and loads the new value, the head or a neighbor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ple_cell
    import ple_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire t_cell_cmd             i_cmd,
    input  wire logic [DATA_WIDTH-1:0] i_val,
    input  wire logic [DATA_WIDTH-1:0] i_prev,
    input  wire logic [DATA_WIDTH-1:0] i_next,
    input  wire logic [DATA_WIDTH-1:0] i_head,
    output logic      [DATA_WIDTH-1:0] o_data
);

    localparam logic [POS_W-1:0] K  = POS_W'(IDX);
    localparam logic [POS_W-1:0] K1 = POS_W'(IDX + 1);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_cmd.kind)
            CMD_INSERT: begin
                if (K == i_cmd.idx) begin
                    n_data = i_val;
                end else if (K > i_cmd.idx && K <= i_cmd.n) begin
                    n_data = i_prev;
                end
            end
            CMD_DELETE: begin
                if (K >= i_cmd.idx && K1 < i_cmd.n) begin
                    n_data = i_next;
                end
            end
            CMD_ROTATE: begin
                // the head wraps to the tail of the occupied run
                if (K1 < i_cmd.n) begin
                    n_data = i_next;
                end else if (K1 == i_cmd.n) begin
                    n_data = i_head;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire
